// ----- src/dapa_pkg.sv -----
// ----------------------------------------------------------------------------
// dapa_pkg: shared types and constants for the dominant axis plane angle block
// Holds the field widths, the arctangent table and the records that travel
// along the CORDIC cell row.
// ----------------------------------------------------------------------------
package dapa_pkg;

  localparam int COORD_WIDTH    = 24;
  localparam int CORDIC_STAGES  = 16;
  localparam int NUM_COORDS     = 9;
  localparam int IN_DATA_W      = ((NUM_COORDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int DIFF_W         = COORD_WIDTH + 1;
  localparam int XY_W           = COORD_WIDTH + 3;
  localparam int ANGLE_W        = 16;
  localparam int OUT_DATA_W     = 16;
  localparam int OUT_USER_W     = 3;
  localparam int ATAN_TABLE_LEN = 24;
  localparam int IDX_W          = $clog2(ATAN_TABLE_LEN);

  localparam logic signed [ANGLE_W-1:0] HALF_PI = ANGLE_W'(12868);
  localparam logic signed [ANGLE_W-1:0] PI_MAX  = ANGLE_W'(25736);

  localparam logic signed [ANGLE_W-1:0] ATAN_Q13 [ATAN_TABLE_LEN] = '{
    ANGLE_W'(6434), ANGLE_W'(3798), ANGLE_W'(2007), ANGLE_W'(1019),
    ANGLE_W'(511),  ANGLE_W'(256),  ANGLE_W'(128),  ANGLE_W'(64),
    ANGLE_W'(32),   ANGLE_W'(16),   ANGLE_W'(8),    ANGLE_W'(4),
    ANGLE_W'(2),    ANGLE_W'(1),    ANGLE_W'(0),    ANGLE_W'(0),
    ANGLE_W'(0),    ANGLE_W'(0),    ANGLE_W'(0),    ANGLE_W'(0),
    ANGLE_W'(0),    ANGLE_W'(0),    ANGLE_W'(0),    ANGLE_W'(0)
  };

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  last_curve;
    logic  last_set;
    logic  zero;
  } side_t;

  typedef struct packed {
    logic signed [XY_W-1:0]    x;
    logic signed [XY_W-1:0]    y;
    logic signed [ANGLE_W-1:0] z;
    side_t                     side;
  } cell_t;

endpackage

// ----- src/dapa_front.sv -----
// ----------------------------------------------------------------------------
// dapa_front: axis selection and vector setup
// First stage picks the dominant normal axis and forms the three differences;
// second stage selects the plane, folds the vector into the right half plane
// and seeds the CORDIC angle.
// ----------------------------------------------------------------------------
module dapa_front
  import dapa_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic signed [COORD_WIDTH-1:0] normal [3],
  input  logic signed [COORD_WIDTH-1:0] center [3],
  input  logic signed [COORD_WIDTH-1:0] point  [3],
  input  logic                          last_curve,
  input  logic                          last_set,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output cell_t                         dn_data
);

  logic                     a_v_r;
  axis_t                    a_axis_r;
  logic signed [DIFF_W-1:0] a_diff_r [3];
  logic                     a_last_curve_r;
  logic                     a_last_set_r;
  logic                     a_ready;

  logic                     b_v_r;
  cell_t                    b_data_r;

  logic        [COORD_WIDTH-1:0] mag [3];
  axis_t                         axis_nxt;
  logic signed [DIFF_W-1:0]      diff_nxt [3];
  logic signed [DIFF_W-1:0]      d1;
  logic signed [DIFF_W-1:0]      d2;
  logic signed [XY_W-1:0]        e1;
  logic signed [XY_W-1:0]        e2;
  cell_t                         b_data_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k]      = normal[k][COORD_WIDTH-1] ? COORD_WIDTH'(-normal[k]) : normal[k];
      diff_nxt[k] = DIFF_W'(point[k]) - DIFF_W'(center[k]);
    end
    priority if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
      axis_nxt = AXIS_X;
    end else if (mag[1] >= mag[2]) begin
      axis_nxt = AXIS_Y;
    end else begin
      axis_nxt = AXIS_Z;
    end
  end

  assign a_ready  = !b_v_r || dn_ready;
  assign up_ready = !a_v_r || a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (up_ready) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_axis_r       <= axis_nxt;
      a_diff_r       <= diff_nxt;
      a_last_curve_r <= last_curve;
      a_last_set_r   <= last_set;
    end
  end

  always_comb begin
    unique case (a_axis_r)
      AXIS_X: begin
        d1 = a_diff_r[1];
        d2 = a_diff_r[2];
      end
      AXIS_Y: begin
        d1 = a_diff_r[0];
        d2 = a_diff_r[2];
      end
      default: begin
        d1 = a_diff_r[0];
        d2 = a_diff_r[1];
      end
    endcase
    e1 = XY_W'(d1);
    e2 = XY_W'(d2);
    b_data_nxt.side.axis       = a_axis_r;
    b_data_nxt.side.last_curve = a_last_curve_r;
    b_data_nxt.side.last_set   = a_last_set_r;
    b_data_nxt.side.zero       = (d1 == '0) && (d2 == '0);
    priority if (d1[DIFF_W-1] && !d2[DIFF_W-1]) begin
      b_data_nxt.x = e2;
      b_data_nxt.y = -e1;
      b_data_nxt.z = HALF_PI;
    end else if (d1[DIFF_W-1]) begin
      b_data_nxt.x = -e2;
      b_data_nxt.y = e1;
      b_data_nxt.z = -HALF_PI;
    end else begin
      b_data_nxt.x = e1;
      b_data_nxt.y = e2;
      b_data_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (a_ready) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && a_v_r) begin
      b_data_r <= b_data_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_data  = b_data_r;

endmodule

// ----- src/dapa_cell.sv -----
// ----------------------------------------------------------------------------
// dapa_cell: one vectoring CORDIC iteration
// Rotates the vector toward the x axis by the table angle for its position
// in the row and registers the result for the next cell.
// ----------------------------------------------------------------------------
module dapa_cell
  import dapa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] stage_idx,
  input  logic             up_valid,
  output logic             up_ready,
  input  cell_t            up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output cell_t            dn_data
);

  logic                   v_r;
  cell_t                  data_r;
  cell_t                  data_nxt;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  always_comb begin
    xs            = up_data.x >>> stage_idx;
    ys            = up_data.y >>> stage_idx;
    data_nxt.side = up_data.side;
    if (!up_data.y[XY_W-1]) begin
      data_nxt.x = up_data.x + ys;
      data_nxt.y = up_data.y - xs;
      data_nxt.z = up_data.z + ATAN_Q13[stage_idx];
    end else begin
      data_nxt.x = up_data.x - ys;
      data_nxt.y = up_data.y + xs;
      data_nxt.z = up_data.z - ATAN_Q13[stage_idx];
    end
  end

  assign up_ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

// ----- src/dominant_axis_plane_angle.sv -----
// ----------------------------------------------------------------------------
// dominant_axis_plane_angle: angle of a sample point in the dominant plane
// Drops the normal's largest axis and returns atan2 of the point-minus-center
// differences in the two remaining axes, in signed Q3.13 radians.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock while the output is not stalled and
// returns one result per input, in order. Each item passes through two setup
// stages, the row of CORDIC cells (one iteration per cell) and the output
// register. Every stage holds its item under backpressure and still accepts a
// new one when the stage ahead frees up, so bubbles in the row are squeezed
// out.
module dominant_axis_plane_angle
  import dapa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // normal_x, normal_y, normal_z, center_x, center_y, center_z,
  // point_x, point_y, point_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tlast,  // last_of_curve
  input  logic [0:0]            in_tuser,  // last_of_set
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // angle
  output logic                  out_tlast, // out_last_of_curve
  output logic [OUT_USER_W-1:0] out_tuser  // dropped_axis, out_last_of_set
);

  logic signed [COORD_WIDTH-1:0] normal [3];
  logic signed [COORD_WIDTH-1:0] center [3];
  logic signed [COORD_WIDTH-1:0] point  [3];

  logic  row_valid [CORDIC_STAGES+1];
  logic  row_ready [CORDIC_STAGES+1];
  cell_t row_data  [CORDIC_STAGES+1];

  logic                      out_v_r;
  logic signed [ANGLE_W-1:0] out_angle_r;
  side_t                     out_side_r;
  logic signed [ANGLE_W-1:0] angle_nxt;
  cell_t                     last_cell;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      normal[k] = $signed(in_tdata[k*COORD_WIDTH +: COORD_WIDTH]);
      center[k] = $signed(in_tdata[(k+3)*COORD_WIDTH +: COORD_WIDTH]);
      point[k]  = $signed(in_tdata[(k+6)*COORD_WIDTH +: COORD_WIDTH]);
    end
  end

  dapa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .normal     (normal),
    .center     (center),
    .point      (point),
    .last_curve (in_tlast),
    .last_set   (in_tuser[0]),
    .dn_valid   (row_valid[0]),
    .dn_ready   (row_ready[0]),
    .dn_data    (row_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    dapa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (IDX_W'(i)),
      .up_valid  (row_valid[i]),
      .up_ready  (row_ready[i]),
      .up_data   (row_data[i]),
      .dn_valid  (row_valid[i+1]),
      .dn_ready  (row_ready[i+1]),
      .dn_data   (row_data[i+1])
    );
  end

  assign last_cell                = row_data[CORDIC_STAGES];
  assign row_ready[CORDIC_STAGES] = !out_v_r || out_tready;

  always_comb begin
    priority if (last_cell.side.zero) begin
      angle_nxt = '0;
    end else if (last_cell.z > PI_MAX) begin
      angle_nxt = PI_MAX;
    end else if (last_cell.z < -PI_MAX) begin
      angle_nxt = -PI_MAX;
    end else begin
      angle_nxt = last_cell.z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (row_ready[CORDIC_STAGES]) begin
      out_v_r <= row_valid[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (row_ready[CORDIC_STAGES] && row_valid[CORDIC_STAGES]) begin
      out_angle_r <= angle_nxt;
      out_side_r  <= last_cell.side;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_angle_r);
  assign out_tlast  = out_side_r.last_curve;
  assign out_tuser  = {out_side_r.last_set, out_side_r.axis};

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata) <= PI_MAX && $signed(out_tdata) >= -PI_MAX))
    else $error("angle outside of plus or minus pi");

  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is being taken");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

endmodule
